FILE: hw/rtl/lpht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants for the linear-probing hash table unit.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int SLOTS_DEF     = 16;
  localparam int KIND_W        = 2;
  localparam int KEY_W         = 32;
  localparam int VALUE_W       = 32;
  localparam int STATUS_W      = 2;
  localparam int INDEX_W       = 4;
  // key bits folded into the home-slot remainder per cycle
  localparam int MOD_STEP_BITS = 8;
  localparam int MOD_CYCLES    = KEY_W / MOD_STEP_BITS;
  localparam int MOD_CNT_W     = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_FIRST,
    ST_PROBE
  } state_t;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic clear_step;
    logic probe_start;
    logic probe_advance;
    logic commit;
    logic report_miss;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic mod_last;
    logic hit;
    logic probe_last;
  } stat_t;

endpackage

FILE: hw/rtl/lpht_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/lpht_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_ctrl
// Sequencer: clearing pass, home-slot reduction, probe loop and response.
// ----------------------------------------------------------------------------
module lpht_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  lpht_pkg::stat_t stat,
  output logic           busy,
  output lpht_pkg::cmd_t cmd
);

  lpht_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpht_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpht_pkg::ST_CLEAR: begin
        if (stat.clear_last) state_nxt = lpht_pkg::ST_IDLE;
      end
      lpht_pkg::ST_IDLE: begin
        if (start) state_nxt = lpht_pkg::ST_MOD;
      end
      lpht_pkg::ST_MOD: begin
        if (stat.mod_last) state_nxt = lpht_pkg::ST_FIRST;
      end
      lpht_pkg::ST_FIRST: begin
        state_nxt = lpht_pkg::ST_PROBE;
      end
      lpht_pkg::ST_PROBE: begin
        if (stat.hit || stat.probe_last) state_nxt = lpht_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lpht_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      lpht_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      lpht_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      lpht_pkg::ST_MOD: begin
        cmd.mod_step = 1'b1;
      end
      lpht_pkg::ST_FIRST: begin
        cmd.probe_start = 1'b1;
      end
      lpht_pkg::ST_PROBE: begin
        if (stat.hit) begin
          cmd.commit = 1'b1;
        end else if (stat.probe_last) begin
          cmd.report_miss = 1'b1;
        end else begin
          cmd.probe_advance = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: hw/rtl/lpht_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_datapath
// Request registers, home-slot remainder, probe pointers, slot RAM, response.
// ----------------------------------------------------------------------------
module lpht_datapath #(
  parameter int SLOTS = lpht_pkg::SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lpht_pkg::cmd_t                    cmd,
  output lpht_pkg::stat_t                   stat,
  input  logic [lpht_pkg::KIND_W-1:0]       in_kind,
  input  logic [lpht_pkg::KEY_W-1:0]        in_key,
  input  logic signed [lpht_pkg::VALUE_W-1:0] in_value,
  output logic                              out_valid,
  output logic [lpht_pkg::STATUS_W-1:0]     out_status,
  output logic [lpht_pkg::INDEX_W-1:0]      out_slot_index
);

  localparam int IW = $clog2(SLOTS);
  localparam int DW = lpht_pkg::VALUE_W + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam logic [IW:0]   SLOTS_X  = (IW + 1)'(SLOTS);

  logic [lpht_pkg::KIND_W-1:0]   kind_r;
  logic [lpht_pkg::VALUE_W-1:0]  val_r;
  logic [lpht_pkg::KEY_W-1:0]    key_r;
  logic [IW-1:0]                 rem_r, rem_nxt;
  logic [lpht_pkg::MOD_CNT_W-1:0] mod_cnt_r;
  logic [IW-1:0]                 clr_idx_r;
  logic [IW-1:0]                 chk_idx_r;
  logic [IW-1:0]                 rd_next_r;
  logic [IW-1:0]                 probe_cnt_r;
  logic [IW-1:0]                 home_inc, next_inc;
  logic                          out_valid_r;
  logic [lpht_pkg::STATUS_W-1:0] status_r;
  logic [lpht_pkg::INDEX_W-1:0]  index_r;

  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;
  logic          slot_used;

  // Fold MOD_STEP_BITS key bits, MSB first, into the running remainder.
  always_comb begin
    logic [IW-1:0] r;
    logic [IW:0]   t;
    r = rem_r;
    for (int j = 0; j < lpht_pkg::MOD_STEP_BITS; j++) begin
      t = {r, key_r[lpht_pkg::KEY_W-1-j]};
      if (t >= SLOTS_X) t = t - SLOTS_X;
      r = t[IW-1:0];
    end
    rem_nxt = r;
  end

  assign home_inc = (rem_r == LAST_IDX) ? '0 : rem_r + 1'b1;
  assign next_inc = (rd_next_r == LAST_IDX) ? '0 : rd_next_r + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= in_kind;
      val_r     <= $unsigned(in_value);
      key_r     <= in_key;
      rem_r     <= '0;
      mod_cnt_r <= '0;
    end else if (cmd.mod_step) begin
      key_r     <= key_r << lpht_pkg::MOD_STEP_BITS;
      rem_r     <= rem_nxt;
      mod_cnt_r <= mod_cnt_r + 1'b1;
    end
    if (cmd.probe_start) begin
      chk_idx_r   <= rem_r;
      rd_next_r   <= home_inc;
      probe_cnt_r <= '0;
    end else if (cmd.probe_advance) begin
      chk_idx_r   <= rd_next_r;
      rd_next_r   <= next_inc;
      probe_cnt_r <= probe_cnt_r + 1'b1;
    end
    if (cmd.commit) begin
      status_r <= lpht_pkg::STATUS_DONE;
      index_r  <= lpht_pkg::INDEX_W'(chk_idx_r);
    end else if (cmd.report_miss) begin
      status_r <= (kind_r == lpht_pkg::KIND_INSERT) ? lpht_pkg::STATUS_FULL
                                                   : lpht_pkg::STATUS_NOT_FOUND;
      index_r  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear_step) clr_idx_r <= clr_idx_r + 1'b1;
      out_valid_r <= cmd.commit || cmd.report_miss;
    end
  end

  // Entry layout: {valid, value}. Clearing writes all zeros.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = chk_idx_r;
    ram_wdata = {1'b1, val_r};
    if (cmd.clear_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_r;
      ram_wdata = '0;
    end else if (cmd.commit) begin
      case (kind_r)
        lpht_pkg::KIND_INSERT: begin
          ram_we    = 1'b1;
          ram_wdata = {1'b1, val_r};
        end
        lpht_pkg::KIND_DELETE: begin
          ram_we    = 1'b1;
          ram_wdata = '0;
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  assign ram_re    = cmd.probe_start || cmd.probe_advance;
  assign ram_raddr = cmd.probe_start ? rem_r : rd_next_r;

  lpht_ram #(
    .WIDTH (DW),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign slot_used = ram_rdata[DW-1];

  always_comb begin
    stat.clear_last = (clr_idx_r == LAST_IDX);
    stat.mod_last   = (mod_cnt_r == lpht_pkg::MOD_CNT_W'(lpht_pkg::MOD_CYCLES - 1));
    stat.probe_last = (probe_cnt_r == LAST_IDX);
    if (kind_r == lpht_pkg::KIND_INSERT) begin
      stat.hit = !slot_used;
    end else begin
      stat.hit = slot_used && (ram_rdata[lpht_pkg::VALUE_W-1:0] == val_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_slot_index = index_r;

endmodule

FILE: hw/rtl/linear_probe_hash_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit
// Linear-probing hash table of SLOTS entries with insert, delete and search.
// ----------------------------------------------------------------------------
// Sequence: after the start transfer the key is reduced to its home slot,
//   the first RAM read is issued, then one slot RAM read per probe cycle,
//   probing 1..SLOTS slots until a hit or the last slot.
// A new request is taken only when busy is low again, with the strobe.
// The result strobe lasts one cycle; the receiver cannot stall it.
// Reset: busy stays high for a clearing pass over every slot of the slot RAM.
module linear_probe_hash_table_unit #(
  parameter int SLOTS = lpht_pkg::SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [lpht_pkg::KIND_W-1:0]         in_kind,
  input  logic [lpht_pkg::KEY_W-1:0]          in_key,
  input  logic signed [lpht_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  output logic [lpht_pkg::STATUS_W-1:0]       out_status,
  output logic [lpht_pkg::INDEX_W-1:0]        out_slot_index
);

  lpht_pkg::cmd_t  cmd;
  lpht_pkg::stat_t stat;

  lpht_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  lpht_datapath #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_kind        (in_kind),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_slot_index (out_slot_index)
  );

  // a transfer always occupies the unit for at least the reduction cycles
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after start transfer");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != lpht_pkg::STATUS_DONE)) |-> (out_slot_index == '0))
    else $error("nonzero index on a miss or full result");

endmodule
